// ===== sv/rspi_pkg.sv =====
package rspi_pkg;

   // Transmit FIFO size; any depth from 16 to 256 entries works.
   localparam int FIFO_DEPTH = 256;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   localparam int NUM_REGS = 24;
   localparam int SLOT_W   = $clog2(NUM_REGS);

   // Request codes on req_type.
   localparam logic [1:0] REQ_XFER       = 2'd0;
   localparam logic [1:0] REQ_CS_RELEASE = 2'd1;
   localparam logic [1:0] REQ_FETCH      = 2'd2;

   localparam logic [6:0] ADDR_FIFO     = 7'h00;
   localparam logic [6:0] ADDR_OPMODE   = 7'h01;
   localparam logic [6:0] ADDR_IRQFLAGS = 7'h12;
   localparam logic [6:0] ADDR_RSSI     = 7'h2C;

   // Slots of the operating mode and IRQ flags registers in the tables below.
   localparam logic [SLOT_W-1:0] SLOT_OPMODE   = SLOT_W'(1);
   localparam logic [SLOT_W-1:0] SLOT_IRQFLAGS = SLOT_W'(11);

   localparam logic [2:0] MODE_MASK      = 3'h7;
   localparam logic [2:0] MODE_STANDBY   = 3'h1;
   localparam logic [2:0] MODE_TX        = 3'h3;
   localparam logic [2:0] MODE_RX_SINGLE = 3'h6;

   localparam logic [7:0] FLAG_TXDONE  = 8'h08;
   localparam logic [7:0] FLAG_RXDONE  = 8'h40;
   localparam logic [7:0] READ_UNKNOWN = 8'hFF;

   localparam logic [6:0] REG_ADDR [NUM_REGS] = '{
      7'h00, 7'h01, 7'h06, 7'h07, 7'h08, 7'h09, 7'h0A, 7'h0C, 7'h0D, 7'h0E, 7'h11, 7'h12,
      7'h1D, 7'h1E, 7'h1F, 7'h22, 7'h2C, 7'h23, 7'h26, 7'h33, 7'h39, 7'h40, 7'h42, 7'h5A
   };

   localparam logic [7:0] REG_DEFAULT [NUM_REGS] = '{
      8'h00, 8'h01, 8'h6C, 8'h80, 8'h00, 8'h4F, 8'h09, 8'h20, 8'h08, 8'h02, 8'h00, 8'h15,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h55, 8'h00, 8'h03, 8'h40, 8'hF5, 8'h00, 8'h12, 8'h84
   };

   typedef enum logic [3:0] {
      PH_WAIT  = 4'b0001,
      PH_READ  = 4'b0010,
      PH_WRITE = 4'b0100,
      PH_FIFO  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] idx;
   } slot_type;

   function automatic slot_type reg_slot(input logic [6:0] addr);
      slot_type s;
      s = '0;
      for (int i = 0; i < NUM_REGS; i++) begin
         if (REG_ADDR[i] == addr) begin
            s.hit = 1'b1;
            s.idx = SLOT_W'(i);
         end
      end
      return s;
   endfunction

   // Reduces a byte position modulo the FIFO depth by restoring subtraction.
   function automatic logic [FIFO_AW-1:0] fifo_index(input logic [7:0] pos);
      logic [12:0] r;
      logic [12:0] d;
      r = {5'b0, pos};
      for (int k = 4; k >= 0; k--) begin
         d = 13'(FIFO_DEPTH) << k;
         if (r >= d) begin
            r = r - d;
         end
      end
      return FIFO_AW'(r);
   endfunction

endpackage

// ===== sv/radio_spi_register_slave.sv =====
// SPI register slave for the radio: every request word (one SPI byte, a chip
// select release or a transmit FIFO fetch) gives exactly one response word.
// A word can be accepted on every clock while req_stall is low; its response moves
// through the stage-one register into the output register. The register file and
// frame state update at the acceptance edge, and the FIFO read is registered at
// that same edge. Each word does at most one write or one read of the transmit
// FIFO memory, one access per cycle. A response waiting in the output register
// does not stop intake, since the stage-one register holds the next word;
// req_stall rises only when both stages are full and rsp_stall is high.
module radio_spi_register_slave (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_type,
   input  logic [7:0] req_mosi,
   input  logic [7:0] req_fetch_index,
   input  logic [7:0] req_rssi_now,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_miso,
   output logic       rsp_irq_line,
   output logic       rsp_tx_start,
   output logic [7:0] rsp_tx_length,
   output logic [7:0] rsp_fifo_byte
);
   import rspi_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [6:0]         addr_ff, addr_in;
   logic [7:0]         reg_ff [NUM_REGS];
   logic [7:0]         reg_in [NUM_REGS];
   logic [FIFO_AW-1:0] count_ff, count_in;
   logic               irq_ff, irq_in;

   logic [7:0]         fifo_mem [FIFO_DEPTH];
   logic               fifo_we;
   logic [7:0]         mem_rd_ff;

   logic               accept;
   slot_type           slot;
   logic [2:0]         mode;
   logic [7:0]         miso_in, len_in;
   logic               start_in, fetch_in;

   logic               s1_valid_ff, s1_move;
   logic [7:0]         s1_miso_ff, s1_len_ff;
   logic               s1_irq_ff, s1_start_ff, s1_fetch_ff;

   logic               out_valid_ff, out_irq_ff, out_start_ff;
   logic [7:0]         out_miso_ff, out_len_ff, out_fifo_ff;

   assign s1_move   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_move;
   assign accept    = req_valid && !req_stall;

   assign slot = reg_slot(addr_ff);
   assign mode = req_mosi[2:0];

   always_comb begin
      phase_in = phase_ff;
      addr_in  = addr_ff;
      reg_in   = reg_ff;
      count_in = count_ff;
      irq_in   = irq_ff;
      fifo_we  = 1'b0;
      miso_in  = '0;
      start_in = 1'b0;
      len_in   = '0;
      fetch_in = 1'b0;
      if (accept) begin
         unique case (req_type)
            REQ_XFER: begin
               miso_in = {1'b0, addr_ff};
               unique case (phase_ff)
                  PH_WAIT: begin
                     phase_in = req_mosi[7] ? PH_WRITE : PH_READ;
                     addr_in  = req_mosi[6:0];
                  end
                  PH_READ: begin
                     if (!slot.hit) begin
                        miso_in = READ_UNKNOWN;
                     end else if (addr_ff == ADDR_RSSI) begin
                        miso_in = req_rssi_now;
                     end else begin
                        miso_in = reg_ff[slot.idx];
                     end
                  end
                  PH_WRITE, PH_FIFO: begin
                     // A write to address zero turns the rest of the frame into FIFO data.
                     if (phase_ff == PH_FIFO || addr_ff == ADDR_FIFO) begin
                        phase_in = PH_FIFO;
                        fifo_we  = 1'b1;
                        count_in = (count_ff == FIFO_AW'(FIFO_DEPTH - 1)) ?
                                   '0 : count_ff + FIFO_AW'(1);
                     end else if (slot.hit) begin
                        if (addr_ff == ADDR_IRQFLAGS) begin
                           reg_in[SLOT_IRQFLAGS] = reg_ff[SLOT_IRQFLAGS] & ~req_mosi;
                           irq_in = 1'b0;
                        end else begin
                           reg_in[slot.idx] = req_mosi;
                           if (addr_ff == ADDR_OPMODE &&
                               (mode == MODE_TX || mode == MODE_RX_SINGLE)) begin
                              reg_in[SLOT_OPMODE] = {req_mosi[7:3], MODE_STANDBY};
                              irq_in = 1'b1;
                              if (mode == MODE_TX) begin
                                 start_in = 1'b1;
                                 len_in   = 8'(count_ff);
                                 count_in = '0;
                                 reg_in[SLOT_IRQFLAGS] = FLAG_TXDONE;
                              end else begin
                                 reg_in[SLOT_IRQFLAGS] = FLAG_RXDONE;
                              end
                           end
                        end
                     end
                  end
                  default: begin
                     phase_in = PH_WAIT;
                  end
               endcase
            end
            REQ_CS_RELEASE: begin
               phase_in = PH_WAIT;
            end
            REQ_FETCH: begin
               fetch_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         addr_ff  <= '0;
         count_ff <= '0;
         irq_ff   <= 1'b0;
         for (int i = 0; i < NUM_REGS; i++) begin
            reg_ff[i] <= REG_DEFAULT[i];
         end
      end else begin
         phase_ff <= phase_in;
         addr_ff  <= addr_in;
         count_ff <= count_in;
         irq_ff   <= irq_in;
         reg_ff   <= reg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_we) begin
         fifo_mem[count_ff] <= req_mosi;
      end
      if (accept && req_type == REQ_FETCH) begin
         mem_rd_ff <= fifo_mem[fifo_index(req_fetch_index)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_miso_ff  <= miso_in;
         s1_irq_ff   <= irq_in;
         s1_start_ff <= start_in;
         s1_len_ff   <= len_in;
         s1_fetch_ff <= fetch_in;
      end
      if (s1_move) begin
         out_miso_ff  <= s1_miso_ff;
         out_irq_ff   <= s1_irq_ff;
         out_start_ff <= s1_start_ff;
         out_len_ff   <= s1_len_ff;
         out_fifo_ff  <= s1_fetch_ff ? mem_rd_ff : 8'h00;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_miso      = out_miso_ff;
   assign rsp_irq_line  = out_irq_ff;
   assign rsp_tx_start  = out_start_ff;
   assign rsp_tx_length = out_len_ff;
   assign rsp_fifo_byte = out_fifo_ff;

endmodule

// ===== sv/rspi_checker.sv =====
module rspi_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_miso,
   input logic       rsp_irq_line,
   input logic       rsp_tx_start,
   input logic [7:0] rsp_tx_length,
   input logic [7:0] rsp_fifo_byte
);

   // No response can be presented in the cycle right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A length is only reported together with a transmit start.
   a_len_only_on_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tx_start |-> rsp_tx_length == 8'h00)
      else $error("tx_length without tx_start");

   // Starting a transmission always raises the interrupt.
   a_start_irq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tx_start |-> rsp_irq_line)
      else $error("tx_start without interrupt");

   // FIFO data only comes back on fetch words, which return nothing to the master.
   a_fetch_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fifo_byte != 8'h00 |-> rsp_miso == 8'h00 && !rsp_tx_start)
      else $error("fifo_byte on a word that is not a fetch");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_miso) && $stable(rsp_fifo_byte))
      else $error("stalled response changed");

endmodule

bind radio_spi_register_slave rspi_checker u_rspi_checker (.*);
